[hdl/tabular_q_learning_engine_core_defines.svh]
// Assertion macros for the Q-learning engine checker.
// Bodies refer to clk_i and rst_ni of the module that uses them.
`ifndef TABULAR_Q_LEARNING_ENGINE_CORE_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define TQLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TQLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tqle_pkg.sv]
// Shared types, constants and row helpers for the Q-learning engine.
// No dependencies.
package tqle_pkg;

  localparam int NUM_STATES  = 1024;
  localparam int ROW_AW      = $clog2(NUM_STATES);
  localparam int NUM_ACTIONS = 4;
  localparam int ACT_W       = 2;
  localparam int Q_W         = 32;
  localparam int ROW_W       = NUM_ACTIONS * Q_W;

  localparam int CMD_W    = 2;
  localparam int STATE_W  = 10;
  localparam int REWARD_W = 16;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [FRAC_W-1:0] LEARN_RATE_RST   = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST     = 16'd58982;
  localparam logic [FRAC_W-1:0] EXPLORE_RATE_RST = 16'd6554;

  typedef enum logic [CMD_W-1:0] {
    CMD_DECIDE = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_WRITE  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE   = 2'd0,
    CFG_DISCOUNT     = 2'd1,
    CFG_EXPLORE_RATE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROW,
    ST_DIFF,
    ST_MUL,
    ST_ADD
  } state_e;

  typedef logic [ROW_W-1:0]      row_t;
  typedef logic signed [Q_W-1:0] q_t;

  function automatic q_t row_entry(row_t row, logic [ACT_W-1:0] a);
    return q_t'(row[a*Q_W +: Q_W]);
  endfunction

  // first maximum wins ties
  function automatic logic [ACT_W-1:0] best_act(row_t row);
    logic [ACT_W-1:0] best;
    best = '0;
    for (int a = 1; a < NUM_ACTIONS; a++) begin
      if (row_entry(row, ACT_W'(a)) > row_entry(row, best)) begin
        best = ACT_W'(a);
      end
    end
    return best;
  endfunction

  function automatic row_t row_merge(row_t row, logic [ACT_W-1:0] a, q_t v);
    row_t res;
    res = row;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (ACT_W'(i) == a) begin
        res[i*Q_W +: Q_W] = v;
      end
    end
    return res;
  endfunction

endpackage

[hdl/tqle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tqle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tabular_q_learning_engine_core.sv]
// Q-learning engine with epsilon-greedy choice; Q table in one row-wide RAM.
// Depends on tqle_pkg and tqle_ram.
// Decide, write, unused cmd: result registered in ST_READ once the output is free.
// Update: result registered in ST_ADD once the output is free, after the steps next row read,
// current row read and first multiply, difference, second multiply, add and write-back.
// No new item is accepted until the result is loaded. Reset clears control and last action and
// loads the rate defaults; table contents are undefined until written.
module tabular_q_learning_engine_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tqle_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tqle_pkg::FRAC_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tqle_pkg::CMD_W-1:0]         cmd_i,
  input  logic [tqle_pkg::STATE_W-1:0]       cur_state_i,
  input  logic [tqle_pkg::STATE_W-1:0]       next_state_i,
  input  logic signed [tqle_pkg::REWARD_W-1:0] reward_i,
  input  logic [tqle_pkg::FRAC_W-1:0]        rand_draw_i,
  input  logic [tqle_pkg::ACT_W-1:0]         rand_action_i,
  input  logic [tqle_pkg::ACT_W-1:0]         write_action_i,
  input  logic signed [tqle_pkg::Q_W-1:0]    write_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tqle_pkg::ACT_W-1:0]         chosen_action_o,
  output logic signed [tqle_pkg::Q_W-1:0]    q_value_o,
  output logic                               saturated_o
);

  import tqle_pkg::*;

  localparam int P1_W = FRAC_W + 1 + Q_W;
  localparam int D_W  = Q_W + 3;
  localparam int P2_W = FRAC_W + 1 + D_W;
  localparam int S_W  = P2_W - FRAC_W + 1;

  state_e state_q, state_d;

  logic [FRAC_W-1:0] learn_q, disc_q, explore_q;
  logic [ACT_W-1:0]  last_act_q, last_act_d;

  logic [CMD_W-1:0]         cmd_q;
  logic [ROW_AW-1:0]        cur_q;
  logic signed [REWARD_W-1:0] reward_q;
  logic [FRAC_W-1:0]        draw_q;
  logic [ACT_W-1:0]         ract_q, wact_q;
  q_t                       wval_q;

  q_t                       qmax_q, qold_q;
  row_t                     row_q;
  logic signed [P1_W-1:0]   prod1_q;
  logic signed [D_W-1:0]    diff_q, diff_d;
  logic signed [P2_W-1:0]   prod2_q;
  logic signed [S_W-1:0]    q_sum;
  q_t                       q_new;
  logic                     q_sat;

  logic                     ram_re, ram_we;
  logic [ROW_AW-1:0]        ram_raddr;
  row_t                     ram_wdata, ram_rdata;

  logic                     out_valid_q, out_busy, out_load;
  logic [ACT_W-1:0]         out_act_q, out_act_d;
  q_t                       out_val_q, out_val_d;
  logic                     out_sat_q, out_sat_d;

  logic                     in_accept;
  logic [ACT_W-1:0]         dec_act;

  tqle_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_STATES)
  ) u_qtab (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;

  assign dec_act = (draw_q < explore_q) ? ract_q : best_act(ram_rdata);

  assign diff_d = {{(D_W-REWARD_W-FRAC_W){reward_q[REWARD_W-1]}}, reward_q, {FRAC_W{1'b0}}}
                + D_W'($signed(prod1_q[P1_W-1:FRAC_W]))
                - D_W'(qold_q);

  assign q_sum = S_W'(qold_q) + S_W'($signed(prod2_q[P2_W-1:FRAC_W]));
  assign q_sat = !((&q_sum[S_W-1:Q_W-1]) || !(|q_sum[S_W-1:Q_W-1]));
  always_comb begin
    if (q_sat) begin
      q_new = q_sum[S_W-1] ? q_t'({1'b1, {(Q_W-1){1'b0}}}) : q_t'({1'b0, {(Q_W-1){1'b1}}});
    end else begin
      q_new = q_t'(q_sum[Q_W-1:0]);
    end
  end

  always_comb begin
    state_d    = state_q;
    ram_re     = 1'b0;
    ram_raddr  = cur_q;
    ram_we     = 1'b0;
    ram_wdata  = row_merge(row_q, last_act_q, q_new);
    out_load   = 1'b0;
    out_act_d  = '0;
    out_val_d  = '0;
    out_sat_d  = 1'b0;
    last_act_d = last_act_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ram_re    = 1'b1;
          ram_raddr = (cmd_i == CMD_UPDATE) ? next_state_i[ROW_AW-1:0]
                                            : cur_state_i[ROW_AW-1:0];
          state_d   = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd_q == CMD_UPDATE) begin
          ram_re  = 1'b1;
          state_d = ST_ROW;
        end else if (!out_busy) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          unique case (cmd_q)
            CMD_DECIDE: begin
              out_act_d  = dec_act;
              out_val_d  = row_entry(ram_rdata, dec_act);
              last_act_d = dec_act;
            end
            CMD_WRITE: begin
              ram_we    = 1'b1;
              ram_wdata = row_merge(ram_rdata, wact_q, wval_q);
              out_act_d = wact_q;
              out_val_d = wval_q;
            end
            default: begin
              out_act_d = '0;
            end
          endcase
        end
      end
      ST_ROW:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD: begin
        if (!out_busy) begin
          ram_we    = 1'b1;
          out_load  = 1'b1;
          out_act_d = last_act_q;
          out_val_d = q_new;
          out_sat_d = q_sat;
          state_d   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_act_q  <= '0;
      learn_q     <= LEARN_RATE_RST;
      disc_q      <= DISCOUNT_RST;
      explore_q   <= EXPLORE_RATE_RST;
    end else begin
      state_q    <= state_d;
      last_act_q <= last_act_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_LEARN_RATE:   learn_q   <= cfg_wdata_i;
          CFG_DISCOUNT:     disc_q    <= cfg_wdata_i;
          CFG_EXPLORE_RATE: explore_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= cmd_i;
      cur_q    <= cur_state_i[ROW_AW-1:0];
      reward_q <= reward_i;
      draw_q   <= rand_draw_i;
      ract_q   <= rand_action_i;
      wact_q   <= write_action_i;
      wval_q   <= write_value_i;
    end
    if (state_q == ST_READ) begin
      qmax_q <= row_entry(ram_rdata, best_act(ram_rdata));
    end
    if (state_q == ST_ROW) begin
      row_q   <= ram_rdata;
      qold_q  <= row_entry(ram_rdata, last_act_q);
      prod1_q <= P1_W'($signed({1'b0, disc_q})) * P1_W'(qmax_q);
    end
    if (state_q == ST_DIFF) begin
      diff_q <= diff_d;
    end
    if (state_q == ST_MUL) begin
      prod2_q <= P2_W'($signed({1'b0, learn_q})) * P2_W'(diff_q);
    end
    if (out_load) begin
      out_act_q <= out_act_d;
      out_val_q <= out_val_d;
      out_sat_q <= out_sat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = out_act_q;
  assign q_value_o       = out_val_q;
  assign saturated_o     = out_sat_q;

endmodule

[hdl/tqle_checker.sv]
// Port-level checker for the Q-learning engine, bound to the top level.
// Depends on tqle_pkg and tabular_q_learning_engine_core_defines.svh.
`include "tabular_q_learning_engine_core_defines.svh"

module tqle_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [tqle_pkg::CMD_W-1:0]           cmd_i,
  input logic signed [tqle_pkg::Q_W-1:0]      write_value_i,
  input logic [tqle_pkg::ACT_W-1:0]           write_action_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [tqle_pkg::ACT_W-1:0]           chosen_action_o,
  input logic signed [tqle_pkg::Q_W-1:0]      q_value_o,
  input logic                                 saturated_o
);

  import tqle_pkg::*;

  // stalled result beat holds
  `TQLE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(q_value_o) && $stable(chosen_action_o) && $stable(saturated_o), "stalled result beat changed")

  // one item at a time
  `TQLE_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted a beat while busy")

  // write echoes its value and action, unsaturated, after the row read when the output is free
  `TQLE_ASSERT_NXT(a_write_echo, (in_valid_i && !in_stall_o && cmd_i == CMD_WRITE) ##1 !(out_valid_o && out_stall_i), out_valid_o && q_value_o == $past(write_value_i, 2) && chosen_action_o == $past(write_action_i, 2) && !saturated_o, "write result mismatch")

  // a result only appears while an item is in flight
  `TQLE_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result beat without work")

endmodule

bind tabular_q_learning_engine_core tqle_checker u_tqle_checker (.*);
